// File: src/skhct_pkg.sv
// package for string_key_hash_count_table
// payload structs, fnv constants and status codes; no dependencies
`default_nettype none
package skhct_pkg;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
  localparam int TABLE_LG2_DEF = 12;
  localparam int KEY_LEN_LG2_DEF = 7;
  localparam int STORE_LG2_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_KEY_LONG  = 2'd1,
    ST_TBL_FULL  = 2'd2,
    ST_STORE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [11:0] slot_index;
    logic [31:0] hit_count;
    logic        is_new;
    logic [1:0]  status;
  } out_word_t;
endpackage
`default_nettype wire

// File: src/string_key_hash_count_table.sv
// top level of the key counting hash table: fnv-1a hash, triangular probe,
// string store; uses skhct_pkg
// sequence: a byte word holds busy while the shared 32x32 multiplier runs S_M1, S_M2 and S_M3,
//   so a new word is taken only once the last one is done; a final byte then probes slots, compares
//   stored bytes on a hash hit, copies the key on an insert and updates the count; result strobes as busy drops
// reset clears the hash word of every slot, busy high; no back pressure on results
`default_nettype none
module string_key_hash_count_table #(
  parameter int TABLE_LG2   = skhct_pkg::TABLE_LG2_DEF,
  parameter int KEY_LEN_LG2 = skhct_pkg::KEY_LEN_LG2_DEF,
  parameter int STORE_LG2   = skhct_pkg::STORE_LG2_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire skhct_pkg::in_word_t  in_word,
  output logic                      out_valid,
  output skhct_pkg::out_word_t      out_word
);
  localparam int TS = 1 << TABLE_LG2;
  localparam int KM = 1 << KEY_LEN_LG2;
  localparam int SS = 1 << STORE_LG2;
  localparam int TW = TABLE_LG2;
  localparam int KW = KEY_LEN_LG2 + 1;   // length up to KM
  localparam int SW = STORE_LG2 + 1;     // cursor up to SS

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_M1, S_M2, S_M3, S_RD, S_CHK, S_CMP_RD, S_CMP,
    S_INS, S_UPD_RD, S_UPD
  } state_t;

  // slot memories
  logic [63:0]       mem_hash [TS];
  logic [STORE_LG2-1:0] mem_off [TS];
  logic [KW-1:0]     mem_len  [TS];
  logic [31:0]       mem_cnt  [TS];
  logic [7:0]        store    [SS];
  logic [7:0]        kbuf     [KM];

  state_t            state_r;
  logic [63:0]       hash_r, x_r, prod_r;
  logic [KW-1:0]     klen_r;
  logic              kovf_r;
  logic [TW-1:0]     idx_r;
  logic [TW:0]       step_r;   // also probe count
  logic [KW-1:0]     ci_r;     // compare / copy index
  logic [SW-1:0]     cur_r;
  logic [63:0]       rd_hash_r;
  logic [STORE_LG2-1:0] rd_off_r;
  logic [KW-1:0]     rd_len_r;
  logic [31:0]       rd_cnt_r;
  logic [7:0]        rd_st_r, rd_kb_r;
  logic              last_r;
  logic [TW:0]       clr_r;
  skhct_pkg::out_word_t ow_r;
  logic              ov_r;

  // shared 32x32 multiplier, one partial product per cycle
  logic [31:0] ma, mb;
  logic [63:0] mp;
  always_comb begin
    ma = x_r[31:0];
    mb = skhct_pkg::FNV_PRIME[31:0];
    case (state_r)
      S_M2: begin ma = x_r[63:32]; mb = skhct_pkg::FNV_PRIME[31:0]; end
      S_M3: begin ma = x_r[31:0];  mb = skhct_pkg::FNV_PRIME[63:32]; end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  logic [63:0] h1;
  assign h1 = hash_r | 64'd1;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word  = ow_r;

  // memory accesses
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) mem_hash[clr_r[TW-1:0]] <= '0;
    if (state_r == S_RD) begin
      rd_hash_r <= mem_hash[idx_r];
      rd_off_r  <= mem_off[idx_r];
      rd_len_r  <= mem_len[idx_r];
    end
    if (state_r == S_UPD_RD) rd_cnt_r <= mem_cnt[idx_r];
    if (state_r == S_CMP_RD) begin
      rd_st_r <= store[STORE_LG2'(rd_off_r + STORE_LG2'(ci_r))];
      rd_kb_r <= kbuf[ci_r[KEY_LEN_LG2-1:0]];
    end
    // insert copy: key byte read one cycle, written to the store the next
    if (state_r == S_INS) rd_kb_r <= kbuf[ci_r[KEY_LEN_LG2-1:0]];
    if (state_r == S_INS && ci_r != '0)
      store[STORE_LG2'(cur_r) + STORE_LG2'(ci_r - 1'b1)] <= rd_kb_r;
    if (state_r == S_INS && ci_r == klen_r) begin
      mem_hash[idx_r] <= h1;
      mem_off[idx_r]  <= cur_r[STORE_LG2-1:0];
      mem_len[idx_r]  <= klen_r;
      mem_cnt[idx_r]  <= '0;
    end
    if (state_r == S_UPD && rd_cnt_r != 32'hFFFF_FFFF) mem_cnt[idx_r] <= rd_cnt_r + 32'd1;
    if (state_r == S_IDLE && start && klen_r < KW'(KM))
      kbuf[klen_r[KEY_LEN_LG2-1:0]] <= in_word.key_byte;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      hash_r  <= skhct_pkg::FNV_BASIS;
      klen_r  <= '0;
      kovf_r  <= 1'b0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (TW+1)'(TS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            x_r    <= hash_r ^ {56'd0, in_word.key_byte};
            last_r <= in_word.last_byte;
            if (klen_r < KW'(KM)) klen_r <= klen_r + 1'b1;
            else kovf_r <= 1'b1;
            state_r <= S_M1;
          end
        end
        S_M1: begin prod_r <= mp; state_r <= S_M2; end
        S_M2: begin prod_r[63:32] <= prod_r[63:32] + mp[31:0]; state_r <= S_M3; end
        S_M3: begin
          idx_r  <= prod_r[TW-1:0];
          step_r <= (TW+1)'(1);
          if (last_r && kovf_r) begin
            ow_r <= '{slot_index: '0, hit_count: '0, is_new: 1'b0,
                      status: skhct_pkg::ST_KEY_LONG};
            ov_r <= 1'b1;
            state_r <= S_IDLE;
            hash_r <= skhct_pkg::FNV_BASIS; klen_r <= '0; kovf_r <= 1'b0;
          end else begin
            hash_r  <= {prod_r[63:32] + mp[31:0], prod_r[31:0]};
            state_r <= last_r ? S_RD : S_IDLE;
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          ci_r <= '0;
          if (rd_hash_r == 64'd0) begin
            if ({1'b0, cur_r} + (SW+1)'(klen_r) > (SW+1)'(SS)) begin
              ow_r <= '{slot_index: 12'(idx_r), hit_count: '0, is_new: 1'b0,
                        status: skhct_pkg::ST_STORE_FULL};
              ov_r <= 1'b1;
              state_r <= S_IDLE;
              hash_r <= skhct_pkg::FNV_BASIS; klen_r <= '0;
            end else state_r <= S_INS;
          end else if (rd_hash_r == h1 && rd_len_r == klen_r) begin
            state_r <= (klen_r == '0) ? S_UPD_RD : S_CMP_RD;
          end else if (step_r == (TW+1)'(TS)) begin
            ow_r <= '{slot_index: '0, hit_count: '0, is_new: 1'b0,
                      status: skhct_pkg::ST_TBL_FULL};
            ov_r <= 1'b1;
            state_r <= S_IDLE;
            hash_r <= skhct_pkg::FNV_BASIS; klen_r <= '0;
          end else begin
            idx_r  <= idx_r + step_r[TW-1:0];
            step_r <= step_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_CMP_RD: state_r <= S_CMP;
        S_CMP: begin
          if (rd_st_r != rd_kb_r) begin
            // mismatch, next probe
            if (step_r == (TW+1)'(TS)) begin
              ow_r <= '{slot_index: '0, hit_count: '0, is_new: 1'b0,
                        status: skhct_pkg::ST_TBL_FULL};
              ov_r <= 1'b1;
              state_r <= S_IDLE;
              hash_r <= skhct_pkg::FNV_BASIS; klen_r <= '0;
            end else begin
              idx_r  <= idx_r + step_r[TW-1:0];
              step_r <= step_r + 1'b1;
              state_r <= S_RD;
            end
          end else if (ci_r + 1'b1 == klen_r) state_r <= S_UPD_RD;
          else begin
            ci_r <= ci_r + 1'b1;
            state_r <= S_CMP_RD;
          end
        end
        S_INS: begin
          if (ci_r == klen_r) begin
            cur_r  <= cur_r + SW'(klen_r);
            state_r <= S_UPD_RD;
          end else ci_r <= ci_r + 1'b1;
        end
        S_UPD_RD: state_r <= S_UPD;
        S_UPD: begin
          ow_r <= '{slot_index: 12'(idx_r),
                    hit_count: (rd_cnt_r == 32'hFFFF_FFFF) ? rd_cnt_r : rd_cnt_r + 32'd1,
                    is_new: (rd_hash_r == 64'd0),
                    status: skhct_pkg::ST_OK};
          ov_r <= 1'b1;
          state_r <= S_IDLE;
          hash_r <= skhct_pkg::FNV_BASIS; klen_r <= '0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // results only come from the end of hashing (key too long), the probe checks and the count update
  a_ov_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_M3 || $past(state_r) == S_CHK ||
                   $past(state_r) == S_CMP || $past(state_r) == S_UPD))
    else $error("result strobe from wrong state");
  a_ov_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= SW'(SS))
    else $error("store cursor past end");
endmodule
`default_nettype wire
